// ----- rtl/pce_pkg.sv -----
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants of the Pruefer code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);  // zero-based node index
  localparam int LBL_W     = 7;                  // one-based label / node count
  localparam int GRP       = 8;                  // leaf search: first tree level
  localparam int NGRP      = MAX_NODES / GRP;
  localparam int GRP_W     = $clog2(GRP);
  localparam int NGRP_W    = $clog2(NGRP);

  // read address select
  localparam logic [1:0] RS_A    = 2'd0;
  localparam logic [1:0] RS_B    = 2'd1;
  localparam logic [1:0] RS_LEAF = 2'd2;
  localparam logic [1:0] RS_FOLD = 2'd3;

  // one node table entry: degree and XOR of neighbour indexes
  typedef struct packed {
    logic [NODE_W-1:0] deg;
    logic [NODE_W-1:0] fold;
  } ent_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture edge endpoints
    logic [1:0] rsel;       // table read address select
    logic       cap_a;      // capture first endpoint entry
    logic       wr_a;       // update first endpoint, count edge
    logic       wr_b;       // update second endpoint
    logic       find1;      // leaf search, group stage
    logic       find2;      // leaf search, final stage
    logic       wr_leaf;    // retire leaf, capture its neighbour
    logic       wr_nb;      // update neighbour and emit it
    logic       emit_none;  // no leaf found: emit zero
    logic       clr;        // drop all tree state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic edge_ok;    // edge on the input ports has labels in range
    logic same;       // captured edge is a self loop
    logic tree_done;  // all edges of the tree are in
    logic no_rounds;  // two-node tree
    logic found;      // leaf search hit
    logic last;       // current round is the final one
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/pce_ram.sv -----
// ----------------------------------------------------------------------------
// pce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/pce_dp.sv -----
// ----------------------------------------------------------------------------
// pce_dp
// Datapath: node table, leaf flags, leaf search, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pce_pkg::cmd_t             cmd,
  output pce_pkg::sts_t                  sts,
  input  wire logic [pce_pkg::LBL_W-1:0] in_end_a,
  input  wire logic [pce_pkg::LBL_W-1:0] in_end_b,
  input  wire logic                      cfg_we,
  input  wire logic [pce_pkg::LBL_W-1:0] cfg_wdata,
  output logic                           out_valid,
  output logic      [pce_pkg::LBL_W-1:0] out_code_node,
  output logic                           out_last_of_code
);

  localparam int NW = pce_pkg::NODE_W;
  localparam int LW = pce_pkg::LBL_W;
  localparam int MN = pce_pkg::MAX_NODES;

  logic [LW-1:0]  node_count_r;
  logic [LW-1:0]  n_eff;
  logic [NW-1:0]  ia_r, ib_r;
  logic [NW-1:0]  edges_r, code_idx_r;
  logic [MN-1:0]  valid_r, deg_one_r, removed_r;
  pce_pkg::ent_t  ent_a_r, ent_b_r;
  logic [NW-1:0]  leaf_r, nb_r, fold_l_r;
  logic           rd_vld_r;
  logic [pce_pkg::NGRP-1:0] grp_any_r;
  logic [pce_pkg::GRP_W-1:0] grp_idx_r [pce_pkg::NGRP];
  logic           out_valid_r, out_last_r;
  logic [LW-1:0]  out_code_r;

  logic [$bits(pce_pkg::ent_t)-1:0] ram_rdata;
  pce_pkg::ent_t  rd_ent, ent_n, wr_ent;
  logic [NW-1:0]  raddr, waddr;
  logic           we;
  logic [MN-1:0]  cand;
  logic [LW-1:0]  rounds;
  logic           found;
  logic [NW-1:0]  leaf;
  logic           same;

  // effective node count, clamped to the supported range
  always_comb begin
    n_eff = node_count_r;
    if (node_count_r < LW'(2)) begin
      n_eff = LW'(2);
    end else if (node_count_r > LW'(MN)) begin
      n_eff = LW'(MN);
    end
  end

  assign rounds = n_eff - LW'(2);
  assign same   = (ia_r == ib_r);
  assign rd_ent = rd_vld_r ? pce_pkg::ent_t'(ram_rdata) : '0;

  assign sts.edge_ok   = (in_end_a != '0) && (in_end_b != '0) &&
                         (in_end_a <= n_eff) && (in_end_b <= n_eff);
  assign sts.same      = same;
  assign sts.tree_done = ({1'b0, edges_r} >= (n_eff - LW'(1)));
  assign sts.no_rounds = (n_eff == LW'(2));
  assign sts.found     = found;
  assign sts.last      = (({1'b0, code_idx_r} + LW'(1)) == rounds);

  always_comb begin
    case (cmd.rsel)
      pce_pkg::RS_A:    raddr = ia_r;
      pce_pkg::RS_B:    raddr = ib_r;
      pce_pkg::RS_LEAF: raddr = leaf_r;
      pce_pkg::RS_FOLD: raddr = rd_ent.fold;
      default:          raddr = ia_r;
    endcase
  end

  // neighbour equal to the leaf only on broken input: use the retired leaf
  assign ent_n = (nb_r == leaf_r) ? pce_pkg::ent_t'{deg: '0, fold: fold_l_r} : rd_ent;

  always_comb begin
    we     = 1'b1;
    waddr  = ia_r;
    wr_ent = ent_a_r;
    if (cmd.wr_a) begin
      waddr       = ia_r;
      wr_ent.deg  = ent_a_r.deg + NW'(1) + NW'(same);
      wr_ent.fold = same ? ent_a_r.fold : (ent_a_r.fold ^ ib_r);
    end else if (cmd.wr_b) begin
      waddr       = ib_r;
      wr_ent.deg  = ent_b_r.deg + NW'(1);
      wr_ent.fold = ent_b_r.fold ^ ia_r;
    end else if (cmd.wr_leaf) begin
      waddr       = leaf_r;
      wr_ent.deg  = '0;
      wr_ent.fold = rd_ent.fold;
    end else if (cmd.wr_nb) begin
      waddr       = nb_r;
      wr_ent.deg  = ent_n.deg - NW'(1);
      wr_ent.fold = ent_n.fold ^ leaf_r;
    end else begin
      we = 1'b0;
    end
  end

  pce_ram #(
    .WIDTH ($bits(pce_pkg::ent_t)),
    .DEPTH (MN)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // leaf candidates: degree one, not retired, inside the tree
  always_comb begin
    for (int i = 0; i < MN; i++) begin
      cand[i] = deg_one_r[i] & ~removed_r[i] & (LW'(i) < n_eff);
    end
  end

  // final stage of the leaf search over the registered group results
  always_comb begin
    found = |grp_any_r;
    leaf  = '0;
    for (int g = pce_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        leaf = {pce_pkg::NGRP_W'(g), grp_idx_r[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find1) begin
      for (int g = 0; g < pce_pkg::NGRP; g++) begin
        grp_any_r[g] <= |cand[g*pce_pkg::GRP +: pce_pkg::GRP];
        grp_idx_r[g] <= '0;
        for (int j = pce_pkg::GRP - 1; j >= 0; j--) begin
          if (cand[g*pce_pkg::GRP + j]) begin
            grp_idx_r[g] <= pce_pkg::GRP_W'(j);
          end
        end
      end
    end
    if (cmd.find2) begin
      leaf_r <= leaf;
    end
    if (cmd.load) begin
      ia_r <= NW'(in_end_a - LW'(1));
      ib_r <= NW'(in_end_b - LW'(1));
    end
    if (cmd.cap_a) begin
      ent_a_r <= rd_ent;
    end
    if (cmd.wr_a) begin
      ent_b_r <= rd_ent;
    end
    if (cmd.wr_leaf) begin
      fold_l_r <= rd_ent.fold;
      nb_r     <= rd_ent.fold;
    end
    rd_vld_r <= valid_r[raddr];
    if (cmd.wr_nb) begin
      out_code_r <= {1'b0, nb_r} + LW'(1);
    end else if (cmd.emit_none) begin
      out_code_r <= '0;
    end
    out_last_r <= sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= LW'(MN);
      edges_r      <= '0;
      code_idx_r   <= '0;
      valid_r      <= '0;
      deg_one_r    <= '0;
      removed_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      out_valid_r <= cmd.wr_nb | cmd.emit_none;
      if (cmd.clr) begin
        edges_r    <= '0;
        code_idx_r <= '0;
        valid_r    <= '0;
        deg_one_r  <= '0;
        removed_r  <= '0;
      end else begin
        if (we) begin
          valid_r[waddr]   <= 1'b1;
          deg_one_r[waddr] <= (wr_ent.deg == NW'(1));
        end
        if (cmd.wr_leaf) begin
          removed_r[leaf_r] <= 1'b1;
        end
        if (cmd.wr_a) begin
          edges_r <= edges_r + NW'(1);
        end
        if (cmd.wr_nb || cmd.emit_none) begin
          code_idx_r <= code_idx_r + NW'(1);
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_node    = out_code_r;
  assign out_last_of_code = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/pce_ctrl.sv -----
// ----------------------------------------------------------------------------
// pce_ctrl
// Controller: sequences edge loads, removal rounds and the store clear.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire pce_pkg::sts_t sts,
  output pce_pkg::cmd_t      cmd,
  output logic               busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_A  = 4'd1;
  localparam logic [3:0] S_RD_B  = 4'd2;
  localparam logic [3:0] S_WR_A  = 4'd3;
  localparam logic [3:0] S_WR_B  = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_FIND1 = 4'd6;
  localparam logic [3:0] S_FIND2 = 4'd7;
  localparam logic [3:0] S_RD_L  = 4'd8;
  localparam logic [3:0] S_RD_N  = 4'd9;
  localparam logic [3:0] S_WR_N  = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = pce_pkg::RS_A;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start && sts.edge_ok) begin
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.rsel  = pce_pkg::RS_A;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        cmd.rsel  = pce_pkg::RS_B;
        cmd.cap_a = 1'b1;
        state_nxt = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = sts.same ? S_CHK : S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.tree_done) begin
          state_nxt = S_IDLE;
        end else if (sts.no_rounds) begin
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_FIND1;
        end
      end
      S_FIND1: begin
        cmd.find1 = 1'b1;
        state_nxt = S_FIND2;
      end
      S_FIND2: begin
        cmd.find2 = 1'b1;
        if (sts.found) begin
          state_nxt = S_RD_L;
        end else begin
          cmd.emit_none = 1'b1;
          state_nxt     = sts.last ? S_CLR : S_FIND1;
        end
      end
      S_RD_L: begin
        cmd.rsel  = pce_pkg::RS_LEAF;
        state_nxt = S_RD_N;
      end
      S_RD_N: begin
        cmd.rsel    = pce_pkg::RS_FOLD;
        cmd.wr_leaf = 1'b1;
        state_nxt   = S_WR_N;
      end
      S_WR_N: begin
        cmd.wr_nb = 1'b1;
        state_nxt = sts.last ? S_CLR : S_FIND1;
      end
      S_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prufer_code_encoder.sv -----
// ----------------------------------------------------------------------------
// prufer_code_encoder
// Pruefer sequence encoder for a labelled tree of up to 64 nodes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata set node_count n (clamped to 2..64); write only while idle.
//   An edge (in_end_a, in_end_b, one-based) transfers when start is high and
//   busy is low. An edge with a label of 0 or above n is dropped and busy stays
//   low. A good edge holds busy through two table reads on the one read port
//   of the node table, one or two writes (one for a self loop) and a check.
//   After edge n-1 the block runs n-2 rounds: a two-stage leaf search, a read
//   of the leaf and of its neighbour, then the neighbour update, or only the
//   search when no leaf exists. Each round puts one code element on
//   out_code_node for one cycle with out_valid high; out_last_of_code marks
//   the final one. A clear state follows, then busy falls. The receiver
//   cannot stall the results.
//   Reset (synchronous, rst_n low) empties the node table at once through its
//   valid bits and sets node_count to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module prufer_code_encoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [pce_pkg::LBL_W-1:0] in_end_a,
  input  wire logic [pce_pkg::LBL_W-1:0] in_end_b,
  input  wire logic                      cfg_we,
  input  wire logic [pce_pkg::LBL_W-1:0] cfg_wdata,
  output logic                           out_valid,
  output logic      [pce_pkg::LBL_W-1:0] out_code_node,
  output logic                           out_last_of_code
);

  pce_pkg::cmd_t cmd;
  pce_pkg::sts_t sts;

  pce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  pce_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_end_a         (in_end_a),
    .in_end_b         (in_end_b),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_code_node    (out_code_node),
    .out_last_of_code (out_last_of_code)
  );

  // results only come out of the removal rounds
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer while idle");

  // the final element comes out during the clear state and is never followed by another result
  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_code |=> !out_valid)
    else $error("result after final element");

  // work only begins with an edge transfer
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule

`default_nettype wire
